FILE: design/utf8c_pkg.sv
// ---------------------------------------------------------------------------
// utf8c_pkg
// Shared types, codes and constants of the bounded UTF-8 text checker.
// ---------------------------------------------------------------------------
package utf8c_pkg;

	localparam int unsigned CNT_W          = 13;
	localparam int unsigned MAX_TEXT_BYTES = 4096;
	localparam logic [CNT_W-1:0] LIMIT_CAP = CNT_W'(MAX_TEXT_BYTES);

	localparam logic [7:0] BYTE_TAB    = 8'h09;
	localparam logic [7:0] BYTE_LF     = 8'h0a;
	localparam logic [7:0] BYTE_CR     = 8'h0d;
	localparam logic [7:0] BYTE_SPACE  = 8'h20;
	localparam logic [7:0] BYTE_DEL    = 8'h7f;
	localparam logic [7:0] LEAD2_MIN   = 8'hc2;
	localparam logic [7:0] LEAD3_E0    = 8'he0;
	localparam logic [7:0] LEAD3_ED    = 8'hed;
	localparam logic [7:0] LEAD4_F0    = 8'hf0;
	localparam logic [7:0] LEAD4_MAX   = 8'hf4;
	localparam logic [7:0] CONT_MIN_A0 = 8'ha0;
	localparam logic [7:0] CONT_MAX_9F = 8'h9f;
	localparam logic [7:0] CONT_MIN_90 = 8'h90;
	localparam logic [7:0] CONT_MAX_8F = 8'h8f;

	// register indexes on the config channel
	localparam logic REG_MAX_BYTES = 1'b0;
	localparam logic REG_MAX_CHARS = 1'b1;

	typedef enum logic [2:0] {
		RULE_NONE   = 3'd0,
		RULE_MIN_A0 = 3'd1,
		RULE_MAX_9F = 3'd2,
		RULE_MIN_90 = 3'd3,
		RULE_MAX_8F = 3'd4
	} rule_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_CONTROL = 3'd1,
		ERR_LEAD    = 3'd2,
		ERR_CONT    = 3'd3,
		ERR_RANGE   = 3'd4,
		ERR_BYTES   = 3'd5,
		ERR_CHARS   = 3'd6,
		ERR_TRUNC   = 3'd7
	} err_t;

	typedef struct packed {
		logic [1:0]       pend;
		rule_t            rule;
		logic [CNT_W-1:0] byte_cnt;
		logic [CNT_W-1:0] char_cnt;
		err_t             err;
		logic             content;
	} text_state_t;

	typedef struct packed {
		logic             has_content;
		logic [CNT_W-1:0] char_count;
		err_t             error_code;
		logic             text_ok;
	} verdict_t;

	typedef struct packed {
		logic [CNT_W-1:0] byte_lim;
		logic [CNT_W-1:0] char_lim;
	} limits_t;

	localparam text_state_t STATE_CLEAR = '{
		pend:     2'd0,
		rule:     RULE_NONE,
		byte_cnt: '0,
		char_cnt: '0,
		err:      ERR_NONE,
		content:  1'b0
	};

endpackage

FILE: design/utf8c_cfg.sv
// ---------------------------------------------------------------------------
// utf8c_cfg
// Limit registers, written over the config channel, clamped to the text cap.
// ---------------------------------------------------------------------------
module utf8c_cfg import utf8c_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic             wr_index,
	input  logic [CNT_W-1:0] wr_data,
	output limits_t          limits
);

	logic [CNT_W-1:0] max_bytes_q;
	logic [CNT_W-1:0] max_chars_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= LIMIT_CAP;
			max_chars_q <= LIMIT_CAP;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MAX_BYTES: max_bytes_q <= wr_data;
				REG_MAX_CHARS: max_chars_q <= wr_data;
				default:       ;
			endcase
		end
	end

	assign limits.byte_lim = (max_bytes_q > LIMIT_CAP) ? LIMIT_CAP : max_bytes_q;
	assign limits.char_lim = (max_chars_q > LIMIT_CAP) ? LIMIT_CAP : max_chars_q;

endmodule

FILE: design/utf8c_step.sv
// ---------------------------------------------------------------------------
// utf8c_step
// Next-state logic for one item: byte check and decode, or end-of-text verdict.
// ---------------------------------------------------------------------------
module utf8c_step import utf8c_pkg::*; (
	input  text_state_t cur,
	input  limits_t     limits,
	input  logic        is_end,
	input  logic [7:0]  data_byte,
	output text_state_t nxt,
	output verdict_t    verdict
);

	logic        ws;
	logic        ctrl;
	logic        bad_range;
	logic [1:0]  pend_dec;
	err_t        err_tail;

	always_comb begin
		nxt       = cur;
		ws        = (data_byte == BYTE_SPACE) ||
		            (data_byte >= BYTE_TAB && data_byte <= BYTE_CR);
		ctrl      = (data_byte < BYTE_SPACE && data_byte != BYTE_TAB &&
		             data_byte != BYTE_LF) || (data_byte == BYTE_DEL);
		bad_range = 1'b0;
		pend_dec  = cur.pend - 2'd1;
		err_tail  = cur.err;

		if (!is_end) begin
			if (!ws) nxt.content = 1'b1;
			if (cur.byte_cnt <= limits.byte_lim) nxt.byte_cnt = cur.byte_cnt + 1'b1;
			if (nxt.byte_cnt > limits.byte_lim && cur.err == ERR_NONE) nxt.err = ERR_BYTES;

			if (nxt.err == ERR_NONE) begin
				if (cur.pend == 2'd0) begin
					// start of a character
					priority if (ctrl) begin
						nxt.err = ERR_CONTROL;
					end else if (!data_byte[7]) begin
						if (cur.char_cnt <= limits.char_lim) nxt.char_cnt = cur.char_cnt + 1'b1;
						if (nxt.char_cnt > limits.char_lim) nxt.err = ERR_CHARS;
					end else if (data_byte[7:5] == 3'b110 && data_byte >= LEAD2_MIN) begin
						nxt.pend = 2'd1;
						nxt.rule = RULE_NONE;
					end else if (data_byte[7:4] == 4'b1110) begin
						nxt.pend = 2'd2;
						nxt.rule = (data_byte == LEAD3_E0) ? RULE_MIN_A0 :
						           (data_byte == LEAD3_ED) ? RULE_MAX_9F : RULE_NONE;
					end else if (data_byte[7:3] == 5'b11110 && data_byte <= LEAD4_MAX) begin
						nxt.pend = 2'd3;
						nxt.rule = (data_byte == LEAD4_F0) ? RULE_MIN_90 :
						           (data_byte == LEAD4_MAX) ? RULE_MAX_8F : RULE_NONE;
					end else begin
						nxt.err = ERR_LEAD;
					end
				end else begin
					unique case (cur.rule)
						RULE_MIN_A0: bad_range = data_byte < CONT_MIN_A0;
						RULE_MAX_9F: bad_range = data_byte > CONT_MAX_9F;
						RULE_MIN_90: bad_range = data_byte < CONT_MIN_90;
						RULE_MAX_8F: bad_range = data_byte > CONT_MAX_8F;
						default:     bad_range = 1'b0;
					endcase
					priority if (data_byte[7:6] != 2'b10) begin
						nxt.err = ERR_CONT;
					end else if (bad_range) begin
						nxt.err = ERR_RANGE;
					end else begin
						nxt.rule = RULE_NONE;
						nxt.pend = pend_dec;
						if (pend_dec == 2'd0) begin
							if (cur.char_cnt <= limits.char_lim)
								nxt.char_cnt = cur.char_cnt + 1'b1;
							if (nxt.char_cnt > limits.char_lim) nxt.err = ERR_CHARS;
						end
					end
				end
			end
		end else begin
			// cut sequence counts only when nothing else went wrong
			if (cur.err == ERR_NONE && cur.pend != 2'd0) err_tail = ERR_TRUNC;
			nxt = STATE_CLEAR;
		end

		verdict.text_ok     = (err_tail == ERR_NONE);
		verdict.error_code  = err_tail;
		verdict.char_count  = cur.char_cnt;
		verdict.has_content = cur.content;
	end

endmodule

FILE: design/utf8_bounded_text_checker_top.sv
// ---------------------------------------------------------------------------
// utf8_bounded_text_checker_top
// Strict UTF-8 checker for a byte stream with byte and character limits.
//
//   channel  dir  beats                 payload
//   s_*      in   one per byte / end    tdata = data byte, tlast = end of text
//   m_*      out  one per end of text   tdata = verdict
//   cfg_*    in   one per write         cfg_index selects limit, cfg_data value
//
// One item per cycle unless a held verdict stalls: an input register feeds the
// decode logic, which updates the text state and verdict registers.
// An end item passes its verdict from the input register to the verdict
// register, which drives m_tdata while m_tvalid is high.
// A held verdict stalls an end item in the input register, and the items
// behind it with it; data bytes ahead of that end item keep flowing.
// Reset clears the text state and sets both limits to 4096.
// ---------------------------------------------------------------------------
module utf8_bounded_text_checker_top import utf8c_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] data_byte
	input  logic             s_tlast,   // func: end of text
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,   // [0] text_ok, [3:1] error_code,
	                                    // [16:4] char_count, [17] has_content
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [CNT_W-1:0] cfg_data
);

	limits_t     limits;
	text_state_t state_q;
	text_state_t state_nxt;
	verdict_t    verdict;
	verdict_t    verdict_q;

	logic        valid_s1;
	logic        end_s1;
	logic [7:0]  byte_s1;
	logic        adv_s1;

	assign cfg_ready = 1'b1;

	utf8c_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.limits   (limits)
	);

	// an end item moves on only when the verdict slot frees up
	assign adv_s1   = valid_s1 & (~end_s1 | ~m_tvalid | m_tready);
	assign s_tready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			end_s1  <= s_tlast;
			byte_s1 <= s_tdata;
		end
	end

	utf8c_step u_step (
		.cur       (state_q),
		.limits    (limits),
		.is_end    (end_s1),
		.data_byte (byte_s1),
		.nxt       (state_nxt),
		.verdict   (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= STATE_CLEAR;
			m_tvalid <= 1'b0;
		end else begin
			if (adv_s1) state_q <= state_nxt;
			if (adv_s1 && end_s1) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && end_s1) verdict_q <= verdict;
	end

	assign m_tdata = {6'd0, verdict_q};

endmodule

FILE: design/utf8c_chk.sv
// ---------------------------------------------------------------------------
// utf8c_chk
// Port-level checks on the verdict channel of the text checker.
// ---------------------------------------------------------------------------
module utf8c_chk import utf8c_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// held verdict stays put until transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("verdict changed while stalled");

	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == ERR_NONE)))
		else $error("text_ok disagrees with error_code");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:4] <= (LIMIT_CAP + 13'd1)))
		else $error("char_count above saturation point");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:18] == 6'd0))
		else $error("pad bits set in verdict");

endmodule

bind utf8_bounded_text_checker_top utf8c_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/tb_utf8_bounded_text_checker_top.sv
// ---------------------------------------------------------------------------
// tb_utf8_bounded_text_checker_top
// Self-checking bench for the bounded UTF-8 text checker. Texts go in as byte
// transfers closed by a tlast transfer. A local text tracker predicts each
// verdict, and every verdict transfer is checked field by field against the
// oldest prediction. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module tb_utf8_bounded_text_checker_top;
	timeunit 1ns;
	timeprecision 1ps;

	import utf8c_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 1000;
	localparam int MAX_REPORTS   = 40;
	localparam int FULL_LIMIT    = 100;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata   = 8'h00;
	logic             s_tlast   = 1'b0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [23:0]      m_tdata;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_index = REG_MAX_BYTES;
	logic [CNT_W-1:0] cfg_data  = '0;

	// tracked text state and limits
	logic [1:0]       pend      = 2'd0;
	rule_t            rule      = RULE_NONE;
	logic [CNT_W-1:0] n_bytes   = '0;
	logic [CNT_W-1:0] n_chars   = '0;
	err_t             first_err = ERR_NONE;
	logic             content   = 1'b0;
	logic [CNT_W-1:0] lim_bytes = LIMIT_CAP;
	logic [CNT_W-1:0] lim_chars = LIMIT_CAP;

	verdict_t   verdicts_due[$];
	logic [7:0] text_buf[$];
	int         fails       = 0;
	int         items_sent  = 0;
	int         src_gap_max = 5;
	int         snk_gap_max = 5;

	utf8_bounded_text_checker_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	// ---- text tracker ----

	function automatic logic [CNT_W-1:0] clamp_lim(logic [CNT_W-1:0] v);
		return (v > LIMIT_CAP) ? LIMIT_CAP : v;
	endfunction

	function automatic void raise_err(err_t e);
		if (first_err == ERR_NONE) first_err = e;
	endfunction

	function automatic void count_char();
		logic [CNT_W-1:0] lim;
		lim = clamp_lim(lim_chars);
		if (n_chars <= lim) n_chars++;
		if (n_chars > lim) raise_err(ERR_CHARS);
	endfunction

	function automatic void decode_lead(logic [7:0] b);
		if ((b < BYTE_SPACE && b != BYTE_TAB && b != BYTE_LF) || b == BYTE_DEL) begin
			raise_err(ERR_CONTROL);
		end else if (!b[7]) begin
			count_char();
		end else if (b[7:5] == 3'b110 && b >= LEAD2_MIN) begin
			pend = 2'd1;
			rule = RULE_NONE;
		end else if (b[7:4] == 4'b1110) begin
			pend = 2'd2;
			rule = (b == LEAD3_E0) ? RULE_MIN_A0 : ((b == LEAD3_ED) ? RULE_MAX_9F : RULE_NONE);
		end else if (b[7:3] == 5'b11110 && b <= LEAD4_MAX) begin
			pend = 2'd3;
			rule = (b == LEAD4_F0) ? RULE_MIN_90 : ((b == LEAD4_MAX) ? RULE_MAX_8F : RULE_NONE);
		end else begin
			raise_err(ERR_LEAD);
		end
	endfunction

	function automatic void decode_cont(logic [7:0] b);
		logic out_of_range;
		out_of_range = (rule == RULE_MIN_A0 && b < CONT_MIN_A0) ||
		               (rule == RULE_MAX_9F && b > CONT_MAX_9F) ||
		               (rule == RULE_MIN_90 && b < CONT_MIN_90) ||
		               (rule == RULE_MAX_8F && b > CONT_MAX_8F);
		if (b[7:6] != 2'b10) begin
			raise_err(ERR_CONT);
		end else if (out_of_range) begin
			raise_err(ERR_RANGE);
		end else begin
			rule = RULE_NONE;
			pend = pend - 2'd1;
			if (pend == 2'd0) count_char();
		end
	endfunction

	function automatic void track_byte(logic [7:0] b);
		logic [CNT_W-1:0] lim;
		logic             ws;
		lim = clamp_lim(lim_bytes);
		ws  = (b == BYTE_SPACE) || (b >= BYTE_TAB && b <= BYTE_CR);
		if (b[7] || !ws) content = 1'b1;
		// byte limit goes first, decoding stops once any error is held
		if (n_bytes <= lim) n_bytes++;
		if (n_bytes > lim) raise_err(ERR_BYTES);
		if (first_err == ERR_NONE) begin
			if (pend == 2'd0) decode_lead(b);
			else decode_cont(b);
		end
	endfunction

	function automatic verdict_t close_text();
		verdict_t v;
		if (pend != 2'd0) raise_err(ERR_TRUNC);
		v.text_ok     = (first_err == ERR_NONE);
		v.error_code  = first_err;
		v.char_count  = n_chars;
		v.has_content = content;
		pend      = 2'd0;
		rule      = RULE_NONE;
		n_bytes   = '0;
		n_chars   = '0;
		first_err = ERR_NONE;
		content   = 1'b0;
		return v;
	endfunction

	// ---- verdict side ----

	initial begin : verdict_sink
		int stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = $urandom_range(0, snk_gap_max);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic void check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			fails++;
			if (fails <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	always @(posedge clk) begin : verdict_check
		verdict_t want;
		verdict_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = verdict_t'(m_tdata[17:0]);
			if (verdicts_due.size() == 0) begin
				fails++;
				if (fails <= MAX_REPORTS)
					$display("%0t: verdict transfer with none expected, expected none, actual %h",
					         $time, m_tdata);
			end else begin
				want = verdicts_due.pop_front();
				check_field("text_ok", want.text_ok, got.text_ok);
				check_field("error_code", want.error_code, got.error_code);
				check_field("char_count", want.char_count, got.char_count);
				check_field("has_content", want.has_content, got.has_content);
				check_field("tdata pad", 0, m_tdata[23:18]);
			end
		end
	end

	// ---- stimulus helpers ----

	task automatic send_item(input logic last, input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tlast  <= last;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (last) verdicts_due.push_back(close_text());
		else track_byte(b);
	endtask

	task automatic send_text();
		foreach (text_buf[i]) send_item(1'b0, text_buf[i]);
		send_item(1'b1, 8'($urandom_range(0, 255)));
		text_buf.delete();
	endtask

	// sender holds off until every verdict is back, then lets the pipe empty
	task automatic drain_verdicts();
		s_tvalid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic idx, input logic [CNT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MAX_BYTES) lim_bytes = val;
		else lim_chars = val;
	endtask

	task automatic set_limits(input logic [CNT_W-1:0] nb, input logic [CNT_W-1:0] nc);
		drain_verdicts();
		write_limit(REG_MAX_BYTES, nb);
		write_limit(REG_MAX_CHARS, nc);
		cfg_valid <= 1'b0;
	endtask

	// appends one well-formed character, second-byte bounds hit now and then
	function automatic void add_char();
		logic [7:0] lead;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: text_buf.push_back(8'($urandom_range(8'h20, 8'h7e)));
			4: begin
				case ($urandom_range(0, 2))
					0: text_buf.push_back(BYTE_TAB);
					1: text_buf.push_back(BYTE_LF);
					default: text_buf.push_back(BYTE_SPACE);
				endcase
			end
			5: begin
				text_buf.push_back(8'($urandom_range(LEAD2_MIN, 8'hdf)));
				text_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
			end
			6: begin
				lead = 8'($urandom_range(LEAD3_E0, 8'hef));
				text_buf.push_back(lead);
				if (lead == LEAD3_E0)
					text_buf.push_back(8'($urandom_range(CONT_MIN_A0, 8'hbf)));
				else if (lead == LEAD3_ED)
					text_buf.push_back(8'($urandom_range(8'h80, CONT_MAX_9F)));
				else
					text_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
				text_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
			end
			7: begin
				lead = 8'($urandom_range(LEAD4_F0, LEAD4_MAX));
				text_buf.push_back(lead);
				if (lead == LEAD4_F0)
					text_buf.push_back(8'($urandom_range(CONT_MIN_90, 8'hbf)));
				else if (lead == LEAD4_MAX)
					text_buf.push_back(8'($urandom_range(8'h80, CONT_MAX_8F)));
				else
					text_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
				text_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
				text_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
			end
			8: begin
				if ($urandom_range(0, 1)) begin
					text_buf.push_back(LEAD3_E0);
					text_buf.push_back($urandom_range(0, 1) ? CONT_MIN_A0 : 8'hbf);
				end else begin
					text_buf.push_back(LEAD3_ED);
					text_buf.push_back($urandom_range(0, 1) ? 8'h80 : CONT_MAX_9F);
				end
				text_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
			end
			default: begin
				if ($urandom_range(0, 1)) begin
					text_buf.push_back(LEAD4_F0);
					text_buf.push_back(CONT_MIN_90);
				end else begin
					text_buf.push_back(LEAD4_MAX);
					text_buf.push_back(CONT_MAX_8F);
				end
				text_buf.push_back(8'h80);
				text_buf.push_back(8'hbf);
			end
		endcase
	endfunction

	// breaks a text: noise byte, control byte, cut tail, bound miss or bad lead
	function automatic void corrupt_text();
		int pos;
		pos = (text_buf.size() == 0) ? 0 : $urandom_range(0, text_buf.size() - 1);
		case ($urandom_range(0, 4))
			0: text_buf.insert(pos, 8'($urandom_range(0, 255)));
			1: text_buf.insert(pos, $urandom_range(0, 4) == 0 ? BYTE_DEL :
			                        8'($urandom_range(0, 8'h1f)));
			2: begin
				text_buf.push_back(8'($urandom_range(LEAD2_MIN, LEAD4_MAX)));
				if ($urandom_range(0, 1)) text_buf.push_back(8'($urandom_range(8'h80, 8'hbf)));
			end
			3: begin
				case ($urandom_range(0, 3))
					0: begin
						text_buf.push_back(LEAD3_E0);
						text_buf.push_back(8'($urandom_range(8'h80, CONT_MAX_9F)));
					end
					1: begin
						text_buf.push_back(LEAD3_ED);
						text_buf.push_back(8'($urandom_range(CONT_MIN_A0, 8'hbf)));
					end
					2: begin
						text_buf.push_back(LEAD4_F0);
						text_buf.push_back(8'($urandom_range(8'h80, CONT_MAX_8F)));
					end
					default: begin
						text_buf.push_back(LEAD4_MAX);
						text_buf.push_back(8'($urandom_range(CONT_MIN_90, 8'hbf)));
					end
				endcase
				add_char();
			end
			default: text_buf.insert(pos, $urandom_range(0, 1) ?
			                         8'($urandom_range(8'h80, 8'hc1)) :
			                         8'($urandom_range(8'hf5, 8'hff)));
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] pick_limit();
		case ($urandom_range(0, 3))
			0: return LIMIT_CAP;
			1, 2: return CNT_W'($urandom_range(1, 30));
			default: return CNT_W'($urandom_range(0, LIMIT_CAP));
		endcase
	endfunction

	// ---- tests ----

	task automatic test_basic_texts();
		src_gap_max = 5;
		snk_gap_max = 5;
		send_text();                                            // empty text
		text_buf = '{BYTE_TAB, BYTE_SPACE, BYTE_LF};            // whitespace only
		send_text();
		text_buf = '{8'h00};                                    // zero byte
		send_text();
		text_buf = '{8'hf4, 8'h8f, 8'hbf, 8'hbf, BYTE_DEL};     // top code point, then DEL
		send_text();
		text_buf = '{LEAD3_E0, 8'h9f};                          // below E0 bound
		send_text();
		text_buf = '{8'hff, 8'h41};                             // decoding stops after bad lead
		send_text();
		text_buf = '{LEAD4_F0, CONT_MIN_90, 8'h80};             // cut by end of text
		send_text();
		text_buf = '{LEAD2_MIN, 8'h41};                         // missing continuation
		send_text();
	endtask

	task automatic test_limits();
		set_limits(CNT_W'(1), CNT_W'(1));
		text_buf = '{8'h61, 8'h62};         // byte limit wins over char limit
		send_text();
		set_limits(CNT_W'(2), CNT_W'(1));
		text_buf = '{8'h61, 8'h62};
		send_text();
		set_limits(LIMIT_CAP, '0);
		text_buf = '{8'h61, 8'h62, 8'h63};  // char count stops one past the limit
		send_text();
		send_text();
		set_limits('0, LIMIT_CAP);
		send_text();
		text_buf = '{8'h61};
		send_text();
	endtask

	// limits above the cap get clamped; then texts right at and past a limit
	task automatic test_full_size_text();
		set_limits('1, '1);
		text_buf = '{8'h61, 8'h62};
		send_text();
		set_limits(CNT_W'(FULL_LIMIT), CNT_W'(FULL_LIMIT));
		src_gap_max = 0;
		snk_gap_max = 0;
		repeat (FULL_LIMIT) text_buf.push_back(8'($urandom_range(8'h21, 8'h7e)));
		send_text();
		repeat (FULL_LIMIT + 2) text_buf.push_back(8'($urandom_range(8'h21, 8'h7e)));
		send_text();
	endtask

	task automatic test_random_texts();
		int start;
		int n_texts;
		int n_chars;
		start   = items_sent;
		n_texts = 0;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (n_texts % 12 == 0) set_limits(pick_limit(), pick_limit());
			src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
			snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
			n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
			repeat (n_chars) add_char();
			if ($urandom_range(0, 9) >= 7) corrupt_text();
			send_text();
			n_texts++;
			if ($urandom_range(0, 14) == 0) drain_verdicts();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_texts();
		test_limits();
		test_full_size_text();
		test_random_texts();
		drain_verdicts();
		repeat (8) @(posedge clk);
		if (verdicts_due.size() != 0) begin
			fails += verdicts_due.size();
			$display("%0t: verdicts missing, expected %0d more, actual 0",
			         $time, verdicts_due.size());
		end
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
